FILE: rtl/core/dmpid_pkg.sv
package dmpid_pkg;

  localparam int OPCODE_W       = 3;
  localparam int ERR_W          = 32;
  localparam int GAIN_W         = 24;
  localparam int OUT_W          = 25;
  localparam int CFG_IDX_W      = 3;
  localparam int LOOP_COUNT_DEF = 5;

  // datapath widths
  localparam int DIFF_W = ERR_W + 1;                // e - last and e + last
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;      // signed gain times signed operand
  localparam int FRAC_W = 16;
  localparam int TERM_W = PROD_W - FRAC_W;          // product brought back to q16.16
  localparam int PD_W   = TERM_W + 1;
  localparam int SUM_W  = PD_W + 1;

  localparam int ANGLE_HALF = 32768;                // half of 2^16
  localparam int RATE_HALF  = 16384000;             // half of 2^16 * 500
  localparam int LIMIT_MAIN = 11796480;             // 180.0
  localparam int LIMIT_YAW  = 2359296;              // 36.0

  localparam logic [GAIN_W-1:0] YAW_P_RESET = 24'd32768;
  localparam logic [GAIN_W-1:0] YAW_I_RESET = 24'd131072;

  // constant divide for the trapezoidal 1/500 factor: 500 = 4 * 125
  localparam int DIV_DEN     = 500;
  localparam int DIV_N_W     = 34;
  localparam int DIV_LOW_W   = 2;                   // the factor 4 is a shift
  localparam int DIV_M_W     = DIV_N_W - DIV_LOW_W;
  localparam int DIV_RECIP_W = 29;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 29'd274877907;  // ceil(2^35 / 125)
  localparam int DIV_SHIFT   = 35;
  localparam int DIV_P_W     = DIV_M_W + DIV_RECIP_W;
  localparam int DIV_Q_W     = 27;                  // signed quotient, magnitude up to 2^25
  localparam logic signed [TERM_W-1:0] DIV_SAT = 42'sd16777216000;  // 500 * 2^25

  typedef enum logic [OPCODE_W-1:0] {
    OP_ANGLE_ROLL  = 3'd0,
    OP_ANGLE_PITCH = 3'd1,
    OP_RATE_ROLL   = 3'd2,
    OP_RATE_PITCH  = 3'd3,
    OP_RATE_YAW    = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_P = 3'd0,
    CFG_ANGLE_I = 3'd1,
    CFG_ANGLE_D = 3'd2,
    CFG_RATE_P  = 3'd3,
    CFG_RATE_I  = 3'd4,
    CFG_RATE_D  = 3'd5,
    CFG_YAW_P   = 3'd6,
    CFG_YAW_I   = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ROUND_I,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_INTEG,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_d;
    logic mul_i;
    logic round_i;
    logic div_load;
    logic integ;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_valid;
    logic is_rate;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             hit;
  } clamp_t;

endpackage

FILE: rtl/core/dual_mode_pid_clamped.sv
// Five-loop pid unit for a quadcopter cascade (angle roll/pitch, rate roll/pitch/yaw) in
// signed q16.16. One transaction at a time: an angle step multiplies, rounds, integrates
// and finishes; a rate step also divides its trapezoidal integral by 500 as a shift by 2
// and a multiply by a scaled reciprocal of 125; a clear or unused opcode goes from the p
// multiply straight to finish. A stalled result adds its wait. The p, d and i products
// share one 25x33 multiplier, the divide has its own 32x29 one. The user must write gains
// through the cfg port only while no transaction is open; the block does not enforce it.
module dual_mode_pid_clamped import dmpid_pkg::*; #(
  parameter int LOOP_COUNT = LOOP_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic signed [ERR_W-1:0] loop_error_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] drive_o,
  output logic signed [OUT_W-1:0] integral_now_o,
  output logic                    drive_clamped_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [GAIN_W-1:0]       cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  dmpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dmpid_dp #(
    .LOOP_COUNT (LOOP_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .loop_error_i    (loop_error_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .drive_o         (drive_o),
    .integral_now_o  (integral_now_o),
    .drive_clamped_o (drive_clamped_o)
  );

endmodule

FILE: rtl/core/dmpid_div.sv
module dmpid_div import dmpid_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIV_N_W-1:0]        num_i,
  input  logic                      neg_i,
  output logic                      done_o,
  output logic signed [DIV_Q_W-1:0] quot_o
);

  logic [DIV_M_W-1:0] num_q;
  logic [DIV_P_W-1:0] prod_q;
  logic               busy_q, done_q, neg_q;
  logic [DIV_Q_W-1:0] mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // n / 500 as (n / 4) / 125; the reciprocal of 125 scaled by 2^35 is exact below 2^32
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i[DIV_N_W-1:DIV_LOW_W];
      neg_q <= neg_i;
    end
    if (busy_q) begin
      prod_q <= num_q * DIV_RECIP;
    end
  end

  assign mag    = DIV_Q_W'(prod_q[DIV_P_W-1:DIV_SHIFT]);
  assign quot_o = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o = done_q;

endmodule

FILE: rtl/core/dmpid_dp.sv
module dmpid_dp import dmpid_pkg::*; #(
  parameter int LOOP_COUNT = LOOP_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic signed [ERR_W-1:0] loop_error_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [GAIN_W-1:0]       cfg_data_i,
  output logic signed [OUT_W-1:0] drive_o,
  output logic signed [OUT_W-1:0] integral_now_o,
  output logic                    drive_clamped_o
);

  localparam int LOOP_W = (LOOP_COUNT > 1) ? $clog2(LOOP_COUNT) : 1;

  logic [GAIN_W-1:0] angle_p_q, angle_i_q, angle_d_q;
  logic [GAIN_W-1:0] rate_p_q, rate_i_q, rate_d_q;
  logic [GAIN_W-1:0] yaw_p_q, yaw_i_q;

  logic signed [ERR_W-1:0] last_q  [LOOP_COUNT];
  logic signed [OUT_W-1:0] integ_q [LOOP_COUNT];

  logic [OPCODE_W-1:0]      opcode_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q, tsum_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] pterm_q, dterm_q, iq_q;
  logic signed [PD_W-1:0]   pd_q;
  logic signed [OUT_W-1:0]  iterm_q;
  logic signed [OUT_W-1:0]  drive_q, integ_now_q;
  logic                     clamped_q;

  logic                     op_valid, is_angle, is_yaw, is_rate, is_clear;
  logic [LOOP_W-1:0]        idx;
  logic signed [ERR_W-1:0]  last_rd;
  logic signed [OUT_W-1:0]  integ_rd;
  logic [GAIN_W-1:0]        pg, ig, dg, gain_sel;
  logic signed [GAIN_W:0]   mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d, rnd_sum, rnd_shift;
  logic signed [TERM_W-1:0] rnd_val, zsat, zmag, i_add;
  logic                     div_done;
  logic signed [DIV_Q_W-1:0] div_quot;
  clamp_t                   iclamp, oclamp;

  function automatic clamp_t clamp_lim(input logic signed [SUM_W-1:0] v, input logic yaw);
    logic signed [SUM_W-1:0] lim;
    clamp_t res;
    lim = yaw ? SUM_W'(LIMIT_YAW) : SUM_W'(LIMIT_MAIN);
    if (v > lim) begin
      res.val = lim[OUT_W-1:0];
      res.hit = 1'b1;
    end else if (v < -lim) begin
      res.val = OUT_W'(-lim);
      res.hit = 1'b1;
    end else begin
      res.val = v[OUT_W-1:0];
      res.hit = 1'b0;
    end
    return res;
  endfunction

  // loop decode
  assign is_clear = (opcode_q == OP_CLEAR);
  assign op_valid = ({1'b0, opcode_q} < (OPCODE_W+1)'(LOOP_COUNT)) &&
                    (opcode_q < OP_CLEAR);
  assign is_angle = (opcode_q == OP_ANGLE_ROLL) || (opcode_q == OP_ANGLE_PITCH);
  assign is_yaw   = (opcode_q == OP_RATE_YAW);
  assign is_rate  = op_valid && !is_angle;
  assign idx      = op_valid ? opcode_q[LOOP_W-1:0] : '0;
  assign last_rd  = last_q[idx];
  assign integ_rd = integ_q[idx];

  always_comb begin
    if (is_angle) begin
      pg = angle_p_q;
      ig = angle_i_q;
      dg = angle_d_q;
    end else if (is_yaw) begin
      pg = yaw_p_q;
      ig = yaw_i_q;
      dg = '0;
    end else begin
      pg = rate_p_q;
      ig = rate_i_q;
      dg = rate_d_q;
    end
  end

  // shared multiplier
  always_comb begin
    if (cmd_i.mul_p) begin
      gain_sel = pg;
      mul_b    = DIFF_W'(err_q);
    end else if (cmd_i.mul_d) begin
      gain_sel = dg;
      mul_b    = diff_q;
    end else begin
      gain_sel = ig;
      mul_b    = is_angle ? DIFF_W'(err_q) : tsum_q;
    end
  end

  assign mul_a  = $signed({1'b0, gain_sel});
  assign prod_d = mul_a * mul_b;

  // round to nearest, ties up; rate integral adds half of 2^16 * 500
  assign rnd_sum   = prod_q + ((cmd_i.round_i && is_rate) ? PROD_W'(RATE_HALF)
                                                           : PROD_W'(ANGLE_HALF));
  assign rnd_shift = rnd_sum >>> FRAC_W;
  assign rnd_val   = rnd_shift[TERM_W-1:0];

  // saturate before the divide: beyond this the integral clamps anyway
  always_comb begin
    if (iq_q > DIV_SAT) begin
      zsat = DIV_SAT;
    end else if (iq_q < -DIV_SAT) begin
      zsat = -DIV_SAT;
    end else begin
      zsat = iq_q;
    end
    // floor for negatives: negate and add den - 1
    zmag = zsat[TERM_W-1] ? (TERM_W'(DIV_DEN - 1) - zsat) : zsat;
  end

  dmpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_load),
    .num_i   (zmag[DIV_N_W-1:0]),
    .neg_i   (zsat[TERM_W-1]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign i_add  = is_rate ? TERM_W'(div_quot) : iq_q;
  assign iclamp = clamp_lim(SUM_W'(integ_rd) + SUM_W'(i_add), is_yaw);
  assign oclamp = clamp_lim(SUM_W'(pd_q) + SUM_W'(iterm_q), is_yaw);

  assign stat_o.op_valid = op_valid;
  assign stat_o.is_rate  = is_rate;
  assign stat_o.div_done = div_done;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_p_q <= '0;
      angle_i_q <= '0;
      angle_d_q <= '0;
      rate_p_q  <= '0;
      rate_i_q  <= '0;
      rate_d_q  <= '0;
      yaw_p_q   <= YAW_P_RESET;
      yaw_i_q   <= YAW_I_RESET;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_ANGLE_P: angle_p_q <= cfg_data_i;
        CFG_ANGLE_I: angle_i_q <= cfg_data_i;
        CFG_ANGLE_D: angle_d_q <= cfg_data_i;
        CFG_RATE_P:  rate_p_q  <= cfg_data_i;
        CFG_RATE_I:  rate_i_q  <= cfg_data_i;
        CFG_RATE_D:  rate_d_q  <= cfg_data_i;
        CFG_YAW_P:   yaw_p_q   <= cfg_data_i;
        CFG_YAW_I:   yaw_i_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOOP_COUNT; i++) begin
        last_q[i]  <= '0;
        integ_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int i = 0; i < LOOP_COUNT; i++) begin
        if (is_clear) begin
          last_q[i]  <= '0;
          integ_q[i] <= '0;
        end else if (op_valid && (LOOP_W'(i) == idx)) begin
          last_q[i]  <= err_q;
          integ_q[i] <= iterm_q;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q <= opcode_i;
      err_q    <= loop_error_i;
    end
    if (cmd_i.mul_p) begin
      diff_q <= DIFF_W'(err_q) - DIFF_W'(last_rd);
      tsum_q <= DIFF_W'(err_q) + DIFF_W'(last_rd);
    end
    if (cmd_i.mul_p || cmd_i.mul_d || cmd_i.mul_i) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_d) begin
      pterm_q <= rnd_val;
    end
    if (cmd_i.mul_i) begin
      dterm_q <= rnd_val;
    end
    if (cmd_i.round_i) begin
      iq_q <= rnd_val;
      pd_q <= PD_W'(pterm_q) + PD_W'(dterm_q);
    end
    if (cmd_i.integ) begin
      iterm_q <= iclamp.val;
    end
    if (cmd_i.finish) begin
      if (op_valid) begin
        drive_q     <= oclamp.val;
        integ_now_q <= iterm_q;
        clamped_q   <= oclamp.hit;
      end else begin
        drive_q     <= '0;
        integ_now_q <= '0;
        clamped_q   <= 1'b0;
      end
    end
  end

  assign drive_o         = drive_q;
  assign integral_now_o  = integ_now_q;
  assign drive_clamped_o = clamped_q;

endmodule

FILE: rtl/core/dmpid_ctrl.sv
module dmpid_ctrl import dmpid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL_P;
      ST_MUL_P:    state_d = stat_i.op_valid ? ST_MUL_D : ST_FINISH;
      ST_MUL_D:    state_d = ST_MUL_I;
      ST_MUL_I:    state_d = ST_ROUND_I;
      ST_ROUND_I:  state_d = stat_i.is_rate ? ST_DIV_LOAD : ST_INTEG;
      ST_DIV_LOAD: state_d = ST_DIVIDE;
      ST_DIVIDE:   if (stat_i.div_done) state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_p    = (state_q == ST_MUL_P);
    cmd_o.mul_d    = (state_q == ST_MUL_D);
    cmd_o.mul_i    = (state_q == ST_MUL_I);
    cmd_o.round_i  = (state_q == ST_ROUND_I);
    cmd_o.div_load = (state_q == ST_DIV_LOAD);
    cmd_o.integ    = (state_q == ST_INTEG);
    cmd_o.finish   = (state_q == ST_FINISH) && out_free;
    out_valid_d    = cmd_o.finish || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == ST_DIVIDE))
    else $error("divider done outside divide state");

  a_finish_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_finish_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished transaction did not raise valid");

  a_divide_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && !stat_i.div_done) |=> (state_q == ST_DIVIDE))
    else $error("left divide state before quotient ready");
`endif

endmodule

FILE: tb/sv/dual_mode_pid_clamped_test.sv
`timescale 1ns / 100ps

module dual_mode_pid_clamped_test;
  import dmpid_pkg::*;

  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 238;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 24;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;
  localparam int N_DIRECTED      = 34;

  localparam longint FRAC_ONE = 64'sd65536;
  localparam longint RATE_DIV = 64'sd32768000;    // 2^16 * 500

  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;
  localparam logic signed [OUT_W-1:0] MAIN_LIM = 25'sd11796480;
  localparam logic signed [OUT_W-1:0] YAW_LIM  = 25'sd2359296;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic signed [OUT_W-1:0] integ;
    logic                    hit;
  } pid_out_t;

  typedef struct packed {
    logic                    is_cfg;
    cfg_e                    idx;
    logic [GAIN_W-1:0]       gain;
    logic [OPCODE_W-1:0]     op;
    logic signed [ERR_W-1:0] err;
    logic                    typed;
    pid_out_t                want;
  } step_t;

  localparam pid_out_t ZERO_OUT = '{25'sd0, 25'sd0, 1'b0};

  // gains start at reset values, then edge cases of clamping and rounding, then all gains at max
  step_t directed [N_DIRECTED] = '{
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  ERR_MAX, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_PITCH, ERR_MIN, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_ROLL,   ERR_MAX, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_PITCH,  ERR_MIN, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_YAW,    ERR_MAX, 1'b1, '{YAW_LIM, YAW_LIM, 1'b1}},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_YAW,    ERR_MIN, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_SPARE_6,     ERR_MAX, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_SPARE_7,     ERR_MIN, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_CLEAR,  32'sh5A5A_A5A5, 1'b1, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_YAW,    32'sd0,  1'b1, ZERO_OUT},
    '{1'b1, CFG_ANGLE_P, 24'd65536, OP_CLEAR,   32'sd0,  1'b0, ZERO_OUT},
    // sum exactly at the limit is not flagged, one lsb over is
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  32'sd11796480, 1'b1, '{MAIN_LIM, 25'sd0, 1'b0}},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  32'sd11796481, 1'b1, '{MAIN_LIM, 25'sd0, 1'b1}},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_PITCH, -32'sd11796480, 1'b1, '{-MAIN_LIM, 25'sd0, 1'b0}},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_PITCH, ERR_MIN, 1'b1, '{-MAIN_LIM, 25'sd0, 1'b1}},
    // half-lsb ties round toward plus infinity
    '{1'b1, CFG_ANGLE_P, 24'd1, OP_CLEAR,       32'sd0,  1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  32'sd32768,  1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  -32'sd32768, 1'b0, ZERO_OUT},
    '{1'b1, CFG_ANGLE_P, 24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_ANGLE_I, 24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_ANGLE_D, 24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_RATE_P,  24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_RATE_I,  24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_RATE_D,  24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_YAW_P,   24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b1, CFG_YAW_I,   24'hFF_FFFF, OP_CLEAR, 32'sd0,  1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  ERR_MAX, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_ANGLE_ROLL,  ERR_MIN, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_ROLL,   ERR_MAX, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_ROLL,   ERR_MIN, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_PITCH,  ERR_MAX, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_YAW,    ERR_MIN, 1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_CLEAR,       32'sd0,  1'b0, ZERO_OUT},
    '{1'b0, CFG_ANGLE_P, 24'd0, OP_RATE_PITCH,  -32'sd1, 1'b0, ZERO_OUT}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [OPCODE_W-1:0]     opcode_i = '0;
  logic signed [ERR_W-1:0] loop_error_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] drive_o;
  logic signed [OUT_W-1:0] integral_now_o;
  logic                    drive_clamped_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [GAIN_W-1:0]       cfg_data_i = '0;

  // loop state and gains as the block should hold them
  logic [GAIN_W-1:0] gain_set [8];
  longint            err_hist [LOOP_COUNT_DEF];
  longint            integ_acc [LOOP_COUNT_DEF];
  pid_out_t          pid_due [$];

  int  cycle_cnt;
  int  bad_count;
  int  sent, clears, spares, checked, limit_hits, writes;
  bit  calm;
  bit  hold_req;

  dual_mode_pid_clamped dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .loop_error_i    (loop_error_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o),
    .integral_now_o  (integral_now_o),
    .drive_clamped_o (drive_clamped_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pid_due.size());
    $display("simulation failed");
    $finish;
  end

  // floor((x + d/2) / d), ties go up
  function automatic longint div_round(input longint x, input longint d);
    longint y;
    y = x + d / 2;
    if (y >= 0) return y / d;
    return -((-y + d - 1) / d);
  endfunction

  function automatic pid_out_t compute_pid(input logic [OPCODE_W-1:0] op,
                                           input logic signed [ERR_W-1:0] err);
    pid_out_t r;
    longint   e, prev, pg, ig, dg, lim, pt, dt, it, sum;
    r = '0;
    if (op == OP_CLEAR) begin
      foreach (err_hist[n]) begin
        err_hist[n] = 0;
        integ_acc[n] = 0;
      end
      return r;
    end
    if (op > OP_RATE_YAW) return r;
    e = err;
    prev = err_hist[op];
    if (op <= OP_ANGLE_PITCH) begin
      pg = gain_set[CFG_ANGLE_P];
      ig = gain_set[CFG_ANGLE_I];
      dg = gain_set[CFG_ANGLE_D];
      lim = LIMIT_MAIN;
    end else if (op <= OP_RATE_PITCH) begin
      pg = gain_set[CFG_RATE_P];
      ig = gain_set[CFG_RATE_I];
      dg = gain_set[CFG_RATE_D];
      lim = LIMIT_MAIN;
    end else begin
      pg = gain_set[CFG_YAW_P];
      ig = gain_set[CFG_YAW_I];
      dg = 0;
      lim = LIMIT_YAW;
    end
    pt = div_round(pg * e, FRAC_ONE);
    dt = div_round(dg * (e - prev), FRAC_ONE);
    // rate loops integrate trapezoidally
    if (op <= OP_ANGLE_PITCH) it = integ_acc[op] + div_round(ig * e, FRAC_ONE);
    else it = integ_acc[op] + div_round(ig * (e + prev), RATE_DIV);
    if (it > lim) it = lim;
    else if (it < -lim) it = -lim;
    sum = pt + it + dt;
    r.hit = (sum > lim) || (sum < -lim);
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    err_hist[op] = e;
    integ_acc[op] = it;
    r.drive = sum[OUT_W-1:0];
    r.integ = it[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(4 * 65536));
      4, 5: return GAIN_W'($urandom_range(65536));
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_error();
    int v;
    case ($urandom_range(19))
      0: return ERR_MAX;
      1: return ERR_MIN;
      2: return '0;
      3: return LIMIT_MAIN;
      4: return -LIMIT_MAIN;
      5: return LIMIT_YAW + 1;
      6: return -LIMIT_YAW - 1;
      7, 8, 9, 10, 11, 12: begin
        v = int'($urandom_range(2097152)) - 1048576;
        return v;
      end
      13, 14, 15: begin
        v = int'($urandom_range(134217728)) - 67108864;
        return v;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic flag_fault(input string msg);
    bad_count++;
    if (bad_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // caller lowers cfg_we_i once the batch of writes is done
  task automatic write_gain(input cfg_e idx, input logic [GAIN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    gain_set[idx] = val;
    writes++;
  endtask

  task automatic offer(input logic [OPCODE_W-1:0] op, input logic signed [ERR_W-1:0] err,
                       input logic typed, input pid_out_t want);
    pid_out_t got;
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    loop_error_i <= err;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = compute_pid(op, err);
    pid_due.push_back(typed ? want : got);
    sent++;
    if (op == OP_CLEAR) clears++;
    else if (op > OP_CLEAR) spares++;
  endtask

  task automatic wait_idle();
    while (pid_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_result();
    pid_out_t want;
    if (pid_due.size() == 0) begin
      flag_fault($sformatf("unexpected result at cycle %0d: drive %0d integral %0d",
                           cycle_cnt, drive_o, integral_now_o));
      return;
    end
    want = pid_due.pop_front();
    checked++;
    if (drive_clamped_o) limit_hits++;
    if (drive_o !== want.drive || integral_now_o !== want.integ ||
        drive_clamped_o !== want.hit)
      flag_fault($sformatf({"mismatch on result %0d: drive exp %0d got %0d, ",
                            "integral exp %0d got %0d, clamped exp %0b got %0b"},
                           checked, want.drive, drive_o, want.integ, integral_now_o,
                           want.hit, drive_clamped_o));
  endtask

  // result side: check at each accepting edge, then choose the next stall
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  initial begin
    logic [OPCODE_W-1:0]     op;
    logic signed [ERR_W-1:0] err;
    logic [GAIN_W-1:0]       gv;
    logic                    in_cfg;
    int                      drift [LOOP_COUNT_DEF];
    int                      cur_loop;
    int                      k;

    gain_set = '{default: '0};
    gain_set[CFG_YAW_P] = YAW_P_RESET;
    gain_set[CFG_YAW_I] = YAW_I_RESET;
    foreach (err_hist[n]) begin
      err_hist[n] = 0;
      integ_acc[n] = 0;
      drift[n] = 0;
    end
    in_cfg = 1'b0;
    cur_loop = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (!in_cfg) begin
          in_valid_i <= 1'b0;
          wait_idle();
        end
        write_gain(directed[i].idx, directed[i].gain);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_we_i <= 1'b0;
        in_cfg = 1'b0;
        offer(directed[i].op, directed[i].err, directed[i].typed, directed[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      // first two phases pin every gain to an extreme
      for (int g = 0; g < 8; g++) begin
        gv = (ph == 0) ? '0 : (ph == 1) ? '1 : pick_gain();
        write_gain(cfg_e'(g), gv);
      end
      cfg_we_i <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        calm = (ph == 4 && n < 200);
        if (ph == 2 && n == 60) hold_req = 1'b1;
        if (ph == 3 && n == 120) begin
          in_valid_i <= 1'b0;
          wait_idle();
        end
        k = $urandom_range(99);
        if ($urandom_range(99) < 20) cur_loop = $urandom_range(OP_RATE_YAW);
        if (k < 3) begin
          op = OP_CLEAR;
          err = $urandom();
        end else if (k < 5) begin
          op = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
          err = $urandom();
        end else begin
          // mostly a slowly wandering error on the same loop so integrals build up
          op = OPCODE_W'(cur_loop);
          if ($urandom_range(99) < 70) begin
            drift[cur_loop] += int'($urandom_range(131072)) - 65536;
            err = drift[cur_loop];
          end else begin
            err = pick_error();
          end
        end
        offer(op, err, 1'b0, ZERO_OUT);
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pid_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d transactions (%0d clears, %0d unused opcodes) over %0d gain writes",
             sent, clears, spares, writes);
    $display("checked %0d results, %0d at the output limit, %0d faults",
             checked, limit_hits, bad_count);
    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: dual_mode_pid_clamped.f
rtl/core/dmpid_pkg.sv
rtl/core/dmpid_div.sv
rtl/core/dmpid_dp.sv
rtl/core/dmpid_ctrl.sv
rtl/core/dual_mode_pid_clamped.sv
tb/sv/dual_mode_pid_clamped_test.sv
